// ===== rtl/core/bthc_pkg.sv =====
package bthc_pkg;

    localparam int BTN_W  = 5;
    localparam int KIND_W = 2;
    localparam int CMD_W  = 2;
    localparam int TIME_W = 32;
    localparam int THR_W  = 16;

    localparam logic [THR_W-1:0] THR_RESET = 16'd500;

    // Command codes carried in the input tuser.
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    // Event codes carried in the output tuser.
    localparam logic [KIND_W-1:0] KIND_SINGLE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HELD     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASED = 2'd2;

    // Register index of the hold threshold on the configuration port.
    localparam logic REG_HOLD_THR = 1'b0;

    typedef struct packed {
        logic [BTN_W-1:0]  id;
        logic [KIND_W-1:0] kind;
        logic              last;
    } t_evt;

endpackage

// ===== rtl/core/button_tap_hold_classifier.sv =====
// Tap/hold classifier for a set of buttons.
// Input items arrive on the s_axis channel: tuser carries the command (tick,
// press, release) and tdata the button index. Each tick advances a 32-bit
// time counter and scans every button slot; a press stamps the slot with the
// current time; a release reports a single press or a release after hold.
// Results leave on the m_axis channel: tdata carries the button, tuser the
// event kind, and tlast marks the final result caused by one input item.
// A tick walks every slot in a pipelined scan: one stamp-memory read and one
// subtract-and-compare per slot. A press stamps its slot as it is accepted;
// a release reads the stamp memory, then compares in the release state and
// writes its result to the output register. s_axis_tready is high only between items.
// Held events are kept one deep while scanning, so tlast is known when the
// last one leaves. If the receiver stalls, the result waits in the output
// register and the scan pauses on the next hit until that register frees up.
// Synchronous reset clears time, all slots and the output, and sets the hold
// threshold to 500 ticks. The threshold is written over the APB port at
// byte address 0 and should be changed only while the block is idle.
module button_tap_hold_classifier
    import bthc_pkg::*;
#(
    parameter int NUM_BUTTONS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [4:0] button, [7:5] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] command

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [4:0] button_id, [7:5] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
    output logic        m_axis_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The button field reaches 32 slots at most.
    localparam int SLOT_COUNT = (NUM_BUTTONS < 32) ? NUM_BUTTONS : 32;

    logic [THR_W-1:0] r_hold_thr;
    logic             cfg_write;
    t_evt             evt;

    // The APB port never waits; the register index is the word address.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_thr <= THR_RESET;
        end else if (cfg_write && paddr[2] == REG_HOLD_THR) begin
            r_hold_thr <= pwdata[THR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_HOLD_THR) ? {{(32-THR_W){1'b0}}, r_hold_thr} : '0;

    // The sequencer owns the time counter, the slot state and the output register.
    bthc_seq #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_thr       (r_hold_thr),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_btn       (s_axis_tdata[BTN_W-1:0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_evt       (evt)
    );

    assign m_axis_tdata = {{(8-BTN_W){1'b0}}, evt.id};
    assign m_axis_tuser = evt.kind;
    assign m_axis_tlast = evt.last;

endmodule

// ===== rtl/core/bthc_ram.sv =====
module bthc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bthc_dur_unit.sv =====
module bthc_dur_unit
    import bthc_pkg::*;
(
    input  logic [TIME_W-1:0] i_time,
    input  logic [TIME_W-1:0] i_stamp,
    input  logic [THR_W-1:0]  i_thr,
    output logic              o_reached
);

    logic [TIME_W-1:0] dur;

    // Elapsed time wraps modulo the counter width.
    assign dur       = i_time - i_stamp;
    assign o_reached = dur >= {{(TIME_W-THR_W){1'b0}}, i_thr};

endmodule

// ===== rtl/core/bthc_seq.sv =====
module bthc_seq
    import bthc_pkg::*;
#(
    parameter int SLOT_COUNT = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [THR_W-1:0]  i_thr,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [BTN_W-1:0]  i_btn,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_evt              o_evt
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_REL
    } t_state;

    t_state            r_state, n_state;
    logic [TIME_W-1:0] r_time, n_time;
    logic [SLOT_COUNT-1:0] r_down, n_down;
    logic [SLOT_COUNT-1:0] r_held, n_held;
    logic              r_out_vld, n_out_vld;
    t_evt              r_out, n_out;
    logic              r_pend_vld, n_pend_vld;
    logic [IW-1:0]     r_pend_idx, n_pend_idx;
    logic              r_ev_vld, n_ev_vld;
    logic [IW-1:0]     r_ev_idx, n_ev_idx;
    logic [CW-1:0]     r_idx, n_idx;

    logic              ram_we;
    logic              ram_re;
    logic [IW-1:0]     ram_raddr;
    logic [TIME_W-1:0] ram_rdata;
    logic [TIME_W-1:0] stamp;
    logic              reached;
    logic              in_accept;
    logic              in_range;
    logic [IW-1:0]     in_slot;
    logic              out_free;
    logic              hit;
    logic              stall;
    logic              scan_done;

    bthc_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SLOT_COUNT)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (in_slot),
        .i_wdata (r_time),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A slot that is up always reads as stamp zero.
    assign stamp = r_down[r_ev_idx] ? ram_rdata : '0;

    bthc_dur_unit u_dur (
        .i_time    (r_time),
        .i_stamp   (stamp),
        .i_thr     (i_thr),
        .o_reached (reached)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign in_range   = {1'b0, i_btn} < (BTN_W + 1)'(SLOT_COUNT);
    assign in_slot    = i_btn[IW-1:0];
    assign out_free   = !r_out_vld || i_out_ready;
    assign hit        = r_ev_vld && r_down[r_ev_idx] && !r_held[r_ev_idx] && reached;
    assign stall      = hit && r_pend_vld && !out_free;
    assign scan_done  = !r_ev_vld && (r_idx == CW'(SLOT_COUNT));

    always_comb begin
        n_state    = r_state;
        n_time     = r_time;
        n_down     = r_down;
        n_held     = r_held;
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;
        n_ev_vld   = r_ev_vld;
        n_ev_idx   = r_ev_idx;
        n_idx      = r_idx;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = in_slot;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (i_cmd)
                        CMD_TICK: begin
                            n_time   = r_time + 1'b1;
                            n_idx    = '0;
                            n_ev_vld = 1'b0;
                            n_state  = S_SCAN;
                        end
                        CMD_PRESS: begin
                            if (in_range) begin
                                ram_we          = 1'b1;
                                n_down[in_slot] = 1'b1;
                                n_held[in_slot] = 1'b0;
                            end
                        end
                        CMD_RELEASE: begin
                            if (in_range) begin
                                ram_re   = 1'b1;
                                n_ev_idx = in_slot;
                                n_state  = S_REL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!stall) begin
                    if (hit) begin
                        n_held[r_ev_idx] = 1'b1;
                        if (r_pend_vld) begin
                            n_out_vld = 1'b1;
                            n_out.id   = BTN_W'(r_pend_idx);
                            n_out.kind = KIND_HELD;
                            n_out.last = 1'b0;
                        end
                        n_pend_vld = 1'b1;
                        n_pend_idx = r_ev_idx;
                    end
                    if (r_idx < CW'(SLOT_COUNT)) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_idx[IW-1:0];
                        n_ev_vld  = 1'b1;
                        n_ev_idx  = r_idx[IW-1:0];
                        n_idx     = r_idx + 1'b1;
                    end else begin
                        n_ev_vld = 1'b0;
                    end
                    if (scan_done) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out.id   = BTN_W'(r_pend_idx);
                    n_out.kind = KIND_HELD;
                    n_out.last = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            S_REL: begin
                if (out_free) begin
                    n_out_vld        = 1'b1;
                    n_out.id         = BTN_W'(r_ev_idx);
                    n_out.kind       = reached ? KIND_RELEASED : KIND_SINGLE;
                    n_out.last       = 1'b1;
                    n_down[r_ev_idx] = 1'b0;
                    n_held[r_ev_idx] = 1'b0;
                    n_state          = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_time     <= '0;
            r_down     <= '0;
            r_held     <= '0;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_ev_vld   <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_time     <= n_time;
            r_down     <= n_down;
            r_held     <= n_held;
            r_out_vld  <= n_out_vld;
            r_pend_vld <= n_pend_vld;
            r_ev_vld   <= n_ev_vld;
            r_idx      <= n_idx;
        end
        r_out      <= n_out;
        r_pend_idx <= n_pend_idx;
        r_ev_idx   <= n_ev_idx;
    end

    assign o_out_valid = r_out_vld;
    assign o_evt       = r_out;

    // A held mark only ever exists on a button that is down.
    a_held_implies_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held & ~r_down) == '0)
        else $error("held mark set on a button that is up");

    // Nothing of a scan may linger once the sequencer is idle.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_pend_vld && !r_ev_vld))
        else $error("scan state left behind in idle");

    // An accepted tick advances time by exactly one.
    a_tick_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_cmd == CMD_TICK) |=> (r_time == $past(r_time) + 1'b1))
        else $error("tick did not advance time");

    // A result that is not the last of its run comes only from a tick scan.
    a_mid_run_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.last) |-> (r_state == S_SCAN || r_state == S_FLUSH))
        else $error("unterminated run outside a scan");

endmodule
